/* hdl/rmd160_pkg.sv */
package rmd160_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_LEN,
    ST_EMIT
  } state_e;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hefcdab89;
  localparam logic [31:0] IV2 = 32'h98badcfe;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hc3d2e1f0;

  localparam logic [3:0] SEL_L [80] = '{
    0,1,2,3,4,5,6,7,8,9,10,11,12,13,14,15,
    7,4,13,1,10,6,15,3,12,0,9,5,2,14,11,8,
    3,10,14,4,9,15,8,1,2,7,0,6,13,11,5,12,
    1,9,11,10,0,8,12,4,13,3,7,15,14,5,6,2,
    4,0,5,9,7,12,2,10,14,1,3,8,11,6,15,13};
  localparam logic [3:0] SEL_R [80] = '{
    5,14,7,0,9,2,11,4,13,6,15,8,1,10,3,12,
    6,11,3,7,0,13,5,10,14,15,8,12,4,9,1,2,
    15,5,1,3,7,14,6,9,11,8,12,2,10,0,4,13,
    8,6,4,1,3,11,15,0,5,12,2,13,9,7,10,14,
    12,15,10,4,1,5,8,7,6,2,13,14,0,3,9,11};
  localparam logic [3:0] ROT_L [80] = '{
    11,14,15,12,5,8,7,9,11,13,14,15,6,7,9,8,
    7,6,8,13,11,9,7,15,7,12,15,9,11,7,13,12,
    11,13,6,7,14,9,13,15,14,8,13,6,5,12,7,5,
    11,12,14,15,14,15,9,8,9,14,5,6,8,6,5,12,
    9,15,5,11,6,8,13,12,5,12,13,14,11,8,5,6};
  localparam logic [3:0] ROT_R [80] = '{
    8,9,9,11,13,15,15,5,7,7,8,11,14,14,12,6,
    9,13,15,7,12,8,9,11,7,7,12,7,6,15,13,11,
    9,7,15,11,8,6,6,14,12,13,5,14,13,13,7,5,
    15,5,8,11,14,14,6,14,6,9,12,9,12,5,15,8,
    8,5,12,9,12,5,14,6,8,13,6,5,15,13,11,11};
  localparam logic [31:0] ADD_L [5] = '{
    32'h00000000, 32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc, 32'ha953fd4e};
  localparam logic [31:0] ADD_R [5] = '{
    32'h50a28be6, 32'h5c4dd124, 32'h6d703ef3, 32'h7a6d76e9, 32'h00000000};

  function automatic logic [31:0] boolfn(input logic [2:0] k, input logic [31:0] x,
                                         input logic [31:0] y, input logic [31:0] z);
    case (k)
      3'd0:    return x ^ y ^ z;
      3'd1:    return (x & y) | (~x & z);
      3'd2:    return (x | ~y) ^ z;
      3'd3:    return (x & z) | (y & ~z);
      default: return x ^ (y | ~z);
    endcase
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [3:0] n);
    logic [63:0] w;
    w = {x, x} << n;
    return w[63:32];
  endfunction

endpackage

/* hdl/ripemd160_byte_stream_hasher_top.sv */
// Input: a byte that does not complete a block is taken while idle; a block-completing
// byte holds the input stalled through 80 round steps (both lines in parallel) and the fold.
// Last item: padding, the length word and one or two compressions come before the first
// digest word; then five digest transactions, one per cycle unless stalled.
// Only one item is taken at a time; the input stalls in every state but idle.
// Reset: asynchronous, active low; chaining value to the initial vector,
// block and count cleared. Same state is restored after each digest.
module ripemd160_byte_stream_hasher_top (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  rmd160_pkg::in_item_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output rmd160_pkg::out_item_t out_data_o
);
  rmd160_pkg::state_e state_q, state_d;
  logic [31:0] h_q [5];
  logic [31:0] blk_q [16];
  logic [31:0] cnt_q;
  logic [31:0] l_q [5];
  logic [31:0] r_q [5];
  logic [6:0]  step_q;
  logic        fin_q;
  logic        tail_q;
  logic [2:0]  idx_q;

  logic [2:0]  rnd;
  logic [31:0] lt, lc, rt, rc;
  logic        take;
  logic [5:0]  pos;
  logic [5:0]  fpos;

  assign rnd  = step_q[6:4];
  assign take = in_valid_i && !in_stall_o;
  assign pos  = cnt_q[5:0];
  assign fpos = cnt_q[5:0];

  rmd160_step u_left (
    .fn_i(rnd), .a_i(l_q[0]), .b_i(l_q[1]), .c_i(l_q[2]), .d_i(l_q[3]), .e_i(l_q[4]),
    .w_i(blk_q[rmd160_pkg::SEL_L[step_q]]), .k_i(rmd160_pkg::ADD_L[rnd]),
    .s_i(rmd160_pkg::ROT_L[step_q]), .t_o(lt), .c10_o(lc));
  rmd160_step u_right (
    .fn_i(3'd4 - rnd), .a_i(r_q[0]), .b_i(r_q[1]), .c_i(r_q[2]), .d_i(r_q[3]),
    .e_i(r_q[4]), .w_i(blk_q[rmd160_pkg::SEL_R[step_q]]), .k_i(rmd160_pkg::ADD_R[rnd]),
    .s_i(rmd160_pkg::ROT_R[step_q]), .t_o(rt), .c10_o(rc));

  assign in_stall_o  = (state_q != rmd160_pkg::ST_IDLE);
  assign out_valid_o = (state_q == rmd160_pkg::ST_EMIT);
  assign out_data_o.digest_word = h_q[idx_q];
  assign out_data_o.word_index  = idx_q;
  assign out_data_o.last_word   = (idx_q == 3'd4);

  always_comb begin
    state_d = state_q;
    case (state_q)
      rmd160_pkg::ST_IDLE: begin
        if (take && in_data_i.has_byte && pos == 6'd63) state_d = rmd160_pkg::ST_ROUND;
        else if (take && in_data_i.last) state_d = rmd160_pkg::ST_PAD;
      end
      rmd160_pkg::ST_ROUND: if (step_q == 7'd79) state_d = rmd160_pkg::ST_FOLD;
      rmd160_pkg::ST_FOLD: begin
        if (tail_q) state_d = rmd160_pkg::ST_EMIT;
        else if (fin_q && fpos > 6'd55) state_d = rmd160_pkg::ST_LEN;
        else if (fin_q) state_d = rmd160_pkg::ST_PAD;
        else state_d = rmd160_pkg::ST_IDLE;
      end
      rmd160_pkg::ST_PAD: begin
        if (fpos > 6'd55) state_d = rmd160_pkg::ST_ROUND;
        else state_d = rmd160_pkg::ST_LEN;
      end
      rmd160_pkg::ST_LEN:  state_d = rmd160_pkg::ST_ROUND;
      rmd160_pkg::ST_EMIT: if (!out_stall_i && idx_q == 3'd4) state_d = rmd160_pkg::ST_IDLE;
      default: state_d = rmd160_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rmd160_pkg::ST_IDLE;
      h_q     <= '{rmd160_pkg::IV0, rmd160_pkg::IV1, rmd160_pkg::IV2,
                   rmd160_pkg::IV3, rmd160_pkg::IV4};
      blk_q   <= '{default: 32'd0};
      cnt_q   <= '0;
      step_q  <= '0;
      fin_q   <= 1'b0;
      tail_q  <= 1'b0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        rmd160_pkg::ST_IDLE: begin
          if (take) begin
            fin_q  <= in_data_i.last;
            tail_q <= 1'b0;
            step_q <= '0;
            if (in_data_i.has_byte) begin
              blk_q[pos[5:2]] <= blk_q[pos[5:2]] |
                                 ({24'd0, in_data_i.data_byte} << {pos[1:0], 3'd0});
              cnt_q <= cnt_q + 32'd1;
            end
          end
        end
        rmd160_pkg::ST_ROUND: begin
          step_q <= step_q + 7'd1;
        end
        rmd160_pkg::ST_FOLD: begin
          h_q[0] <= h_q[1] + l_q[2] + r_q[3];
          h_q[1] <= h_q[2] + l_q[3] + r_q[4];
          h_q[2] <= h_q[3] + l_q[4] + r_q[0];
          h_q[3] <= h_q[4] + l_q[0] + r_q[1];
          h_q[4] <= h_q[0] + l_q[1] + r_q[2];
          blk_q  <= '{default: 32'd0};
          step_q <= '0;
          idx_q  <= '0;
        end
        rmd160_pkg::ST_PAD: begin
          blk_q[fpos[5:2]] <= blk_q[fpos[5:2]] | (32'h80 << {fpos[1:0], 3'd0});
          if (fpos <= 6'd55) begin
            blk_q[14] <= cnt_q << 3;
            blk_q[15] <= {29'd0, cnt_q[31:29]};
            tail_q    <= 1'b1;
          end
        end
        rmd160_pkg::ST_LEN: begin
          blk_q[14] <= cnt_q << 3;
          blk_q[15] <= {29'd0, cnt_q[31:29]};
          tail_q    <= 1'b1;
        end
        rmd160_pkg::ST_EMIT: begin
          if (!out_stall_i) begin
            if (idx_q == 3'd4) begin
              idx_q <= '0;
              h_q   <= '{rmd160_pkg::IV0, rmd160_pkg::IV1, rmd160_pkg::IV2,
                         rmd160_pkg::IV3, rmd160_pkg::IV4};
              cnt_q <= '0;
              fin_q <= 1'b0;
              tail_q <= 1'b0;
            end else begin
              idx_q <= idx_q + 3'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == rmd160_pkg::ST_ROUND) begin
      l_q <= '{l_q[4], lt, l_q[1], lc, l_q[3]};
      r_q <= '{r_q[4], rt, r_q[1], rc, r_q[3]};
    end else begin
      l_q <= h_q;
      r_q <= h_q;
    end
  end
endmodule

/* hdl/rmd160_step.sv */
module rmd160_step (
  input  logic [2:0]  fn_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic [31:0] c_i,
  input  logic [31:0] d_i,
  input  logic [31:0] e_i,
  input  logic [31:0] w_i,
  input  logic [31:0] k_i,
  input  logic [3:0]  s_i,
  output logic [31:0] t_o,
  output logic [31:0] c10_o
);
  logic [31:0] sum;
  assign sum   = a_i + rmd160_pkg::boolfn(fn_i, b_i, c_i, d_i) + w_i + k_i;
  assign t_o   = rmd160_pkg::rotl(sum, s_i) + e_i;
  assign c10_o = rmd160_pkg::rotl(c_i, 4'd10);
endmodule

/* hdl/rmd160_checker.sv */
module rmd160_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_stall_o,
  input rmd160_pkg::out_item_t out_data_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i
);
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input open during digest");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");
  a_idx_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.last_word |=>
      out_valid_o && out_data_o.word_index == $past(out_data_o.word_index) + 3'd1)
    else $error("digest word skipped");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && out_data_o.last_word |=> !out_valid_o)
    else $error("digest runs past last word");
endmodule

bind ripemd160_byte_stream_hasher_top rmd160_checker u_rmd160_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_stall_o(in_stall_o),
  .out_data_o(out_data_o), .out_valid_o(out_valid_o), .out_stall_i(out_stall_i));
